[rtl/dtw_cost_accumulator_top_macros.svh]
// Assertion macros shared by the DTW cost accumulator RTL.
// Included by the modules that check their own control logic.
`ifndef DTW_COST_ACCUMULATOR_TOP_MACROS_SVH
`define DTW_COST_ACCUMULATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define DTWCA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dtwca assertion failed");
`define DTWCA_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("dtwca forbidden condition seen");
`else
`define DTWCA_ASSERT(label, clk, rst_n, prop)
`define DTWCA_NEVER(label, clk, rst_n, expr)
`endif

`endif

[rtl/dtwca_pkg.sv]
// Shared types and constants of the DTW cost accumulator.
// No dependencies; imported by the column sequencer, cell and top level.
`timescale 1ns / 1ps

package dtwca_pkg;

  localparam int ROW_LEN_W = 9;

  typedef struct packed {
    logic first_row;
    logic row_end;
    logic last;
  } dtwca_cell_ctl_t;

endpackage

[rtl/dtwca_line_store.sv]
// Previous-row cost memory with registered read and write-to-read forwarding.
// Standalone; instantiated by dtw_cost_accumulator_top.
`timescale 1ns / 1ps

module dtwca_line_store #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data_r,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

endmodule

[rtl/dtwca_index.sv]
// Column sequencer and row length register of the DTW cost accumulator.
// Depends on dtwca_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "dtw_cost_accumulator_top_macros.svh"

module dtwca_index
  import dtwca_pkg::*;
#(
  parameter int MAX_COLS = 256,
  parameter int COL_W    = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [ROW_LEN_W-1:0] cfg_row_length,
  input  logic                 acc_en,
  input  logic                 in_last_cell,
  output logic [COL_W-1:0]     rd_col,
  output dtwca_cell_ctl_t      ctl
);

  localparam int LEN_W = $clog2(MAX_COLS + 1);
  localparam int CMP_W = (LEN_W > ROW_LEN_W) ? LEN_W : ROW_LEN_W;

  logic [ROW_LEN_W-1:0] row_length_r;
  logic [COL_W-1:0]     column_r;
  logic [COL_W-1:0]     column_nxt;
  logic                 first_row_r;
  logic                 first_row_nxt;
  logic [CMP_W-1:0]     len_cmp;
  logic [LEN_W-1:0]     len;
  logic [LEN_W-1:0]     col_ext;
  logic [LEN_W-1:0]     col_clamp;
  logic [LEN_W-1:0]     col_inc;
  logic                 row_end;
  logic                 last_fire;

  assign last_fire = acc_en && in_last_cell;

  always_comb begin
    len_cmp = CMP_W'(row_length_r);
    if (len_cmp == '0) begin
      len = LEN_W'(1);
    end else if (len_cmp > CMP_W'(MAX_COLS)) begin
      len = LEN_W'(MAX_COLS);
    end else begin
      len = len_cmp[LEN_W-1:0];
    end
    col_ext   = LEN_W'(column_r);
    col_clamp = (col_ext >= len) ? (len - LEN_W'(1)) : col_ext;
    col_inc   = col_clamp + LEN_W'(1);
    row_end   = (col_inc >= len);

    if (in_last_cell) begin
      column_nxt    = '0;
      first_row_nxt = 1'b1;
    end else if (row_end) begin
      column_nxt    = '0;
      first_row_nxt = 1'b0;
    end else begin
      column_nxt    = col_inc[COL_W-1:0];
      first_row_nxt = first_row_r;
    end

    rd_col        = col_clamp[COL_W-1:0];
    ctl.first_row = first_row_r;
    ctl.row_end   = row_end;
    ctl.last      = in_last_cell;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LEN_W'(1);
    end else if (cfg_valid) begin
      row_length_r <= cfg_row_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r    <= '0;
      first_row_r <= 1'b1;
    end else if (acc_en) begin
      column_r    <= column_nxt;
      first_row_r <= first_row_nxt;
    end
  end

  `DTWCA_ASSERT(a_last_restarts_matrix, clk, rst_n, last_fire |=> (column_r == '0 && first_row_r))
  `DTWCA_ASSERT(a_col_in_range, clk, rst_n, col_clamp < len)
  `DTWCA_NEVER(a_len_out_of_range, clk, rst_n, len == '0 || len > LEN_W'(MAX_COLS))

endmodule

[rtl/dtwca_cell.sv]
// Cell stage: three-way minimum, saturating add, left/diagonal state and result register.
// Depends on dtwca_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "dtw_cost_accumulator_top_macros.svh"

module dtwca_cell
  import dtwca_pkg::*;
#(
  parameter int LOCAL_COST_BITS = 16,
  parameter int ACC_BITS        = 32,
  parameter int COL_W           = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc_en,
  input  logic [LOCAL_COST_BITS-1:0] in_cost,
  input  dtwca_cell_ctl_t            in_ctl,
  input  logic [COL_W-1:0]           in_col,
  output logic                       in_ready,
  input  logic [ACC_BITS-1:0]        up_mem,
  output logic                       wr_en,
  output logic [COL_W-1:0]           wr_addr,
  output logic [ACC_BITS-1:0]        wr_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ACC_BITS-1:0]        out_total_cost,
  output logic                       out_saturated
);

  localparam int SUM_W = ((ACC_BITS > LOCAL_COST_BITS) ? ACC_BITS : LOCAL_COST_BITS) + 1;
  localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

  logic                       s1_valid_r;
  logic [LOCAL_COST_BITS-1:0] s1_cost_r;
  dtwca_cell_ctl_t            s1_ctl_r;
  logic [COL_W-1:0]           s1_col_r;
  logic                       s1_fire;

  logic [ACC_BITS-1:0] left_r;
  logic [ACC_BITS-1:0] diag_r;
  logic                sat_seen_r;
  logic [ACC_BITS-1:0] left_nxt;
  logic [ACC_BITS-1:0] diag_nxt;
  logic                sat_seen_nxt;

  logic [ACC_BITS-1:0] up;
  logic [ACC_BITS-1:0] best;
  logic [SUM_W-1:0]    sum_w;
  logic                sat;
  logic [ACC_BITS-1:0] sum;

  logic                out_valid_r;
  logic [ACC_BITS-1:0] out_total_r;
  logic                out_sat_r;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_comb begin
    up    = s1_ctl_r.first_row ? ACC_MAX : up_mem;
    best  = (up < left_r) ? up : left_r;
    best  = (diag_r < best) ? diag_r : best;
    sum_w = SUM_W'(best) + SUM_W'(s1_cost_r);
    sat   = (sum_w >= SUM_W'(ACC_MAX));
    sum   = sat ? ACC_MAX : sum_w[ACC_BITS-1:0];

    if (s1_ctl_r.last) begin
      left_nxt     = ACC_MAX;
      diag_nxt     = '0;
      sat_seen_nxt = 1'b0;
    end else if (s1_ctl_r.row_end) begin
      left_nxt     = ACC_MAX;
      diag_nxt     = ACC_MAX;
      sat_seen_nxt = sat_seen_r | sat;
    end else begin
      left_nxt     = sum;
      diag_nxt     = up;
      sat_seen_nxt = sat_seen_r | sat;
    end
  end

  assign wr_en   = s1_fire;
  assign wr_addr = s1_col_r;
  assign wr_data = sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc_en) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_en) begin
      s1_cost_r <= in_cost;
      s1_ctl_r  <= in_ctl;
      s1_col_r  <= in_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r     <= ACC_MAX;
      diag_r     <= '0;
      sat_seen_r <= 1'b0;
    end else if (s1_fire) begin
      left_r     <= left_nxt;
      diag_r     <= diag_nxt;
      sat_seen_r <= sat_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_ctl_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_ctl_r.last) begin
      out_total_r <= sum;
      out_sat_r   <= sat_seen_r | sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_total_cost = out_total_r;
  assign out_saturated  = out_sat_r;

  `DTWCA_ASSERT(a_last_gives_result, clk, rst_n, (s1_fire && s1_ctl_r.last) |=> out_valid_r)
  `DTWCA_NEVER(a_no_accept_when_blocked, clk, rst_n, s1_valid_r && out_valid_r && !out_ready && in_ready)
  `DTWCA_ASSERT(a_last_clears_state, clk, rst_n, (s1_fire && s1_ctl_r.last) |=> (diag_r == '0 && left_r == ACC_MAX && !sat_seen_r))

endmodule

[rtl/dtw_cost_accumulator_top.sv]
// DTW cost accumulator: fills the warping cost matrix one cell per transfer.
// out_valid rises when the last cell has passed the stage-1 register and then the result register.
// Throughput: one cell per cycle; input stalls only while a total waits with a cell behind it.
// The line store read is issued at the transfer and forwards a same-cycle write-back.
// Reset (rst_n low, synchronous): row length 1, a new matrix starts, no result pending.
// The line store is not cleared; entries are valid once a row has written them.
`timescale 1ns / 1ps

module dtw_cost_accumulator_top
  import dtwca_pkg::*;
#(
  parameter int MAX_COLS        = 256,
  parameter int LOCAL_COST_BITS = 16,
  parameter int ACC_BITS        = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ROW_LEN_W-1:0]       cfg_row_length,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [LOCAL_COST_BITS-1:0] in_local_cost,
  input  logic                       in_last_cell,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ACC_BITS-1:0]        out_total_cost,
  output logic                       out_saturated
);

  localparam int COL_W = $clog2(MAX_COLS);

  logic                acc_en;
  logic [COL_W-1:0]    rd_col;
  dtwca_cell_ctl_t     ctl;
  logic [ACC_BITS-1:0] up_mem;
  logic                wr_en;
  logic [COL_W-1:0]    wr_addr;
  logic [ACC_BITS-1:0] wr_data;

  assign cfg_ready = 1'b1;
  assign acc_en    = in_valid && in_ready;

  dtwca_index #(
    .MAX_COLS (MAX_COLS),
    .COL_W    (COL_W)
  ) u_index (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_row_length (cfg_row_length),
    .acc_en         (acc_en),
    .in_last_cell   (in_last_cell),
    .rd_col         (rd_col),
    .ctl            (ctl)
  );

  dtwca_line_store #(
    .DEPTH  (MAX_COLS),
    .ADDR_W (COL_W),
    .DATA_W (ACC_BITS)
  ) u_line_store (
    .clk       (clk),
    .rd_en     (acc_en),
    .rd_addr   (rd_col),
    .rd_data_r (up_mem),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  dtwca_cell #(
    .LOCAL_COST_BITS (LOCAL_COST_BITS),
    .ACC_BITS        (ACC_BITS),
    .COL_W           (COL_W)
  ) u_cell (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc_en         (acc_en),
    .in_cost        (in_local_cost),
    .in_ctl         (ctl),
    .in_col         (rd_col),
    .in_ready       (in_ready),
    .up_mem         (up_mem),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_total_cost (out_total_cost),
    .out_saturated  (out_saturated)
  );

endmodule
